[rtl/cac_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cac_pkg
// shared types and constants for the circle / box collision test
// ----------------------------------------------------------------------------
package cac_pkg;

	// clamped magnitude of a coordinate difference
	localparam int MagW = 18;
	localparam int Clamp = 131072;
	localparam int SqW = 2 * MagW;
	localparam int SumW = SqW + 1;
	localparam int R2W = 32;

	// classified item handed from the front to the back
	typedef struct packed {
		logic [MagW-1:0] dxl;
		logic [MagW-1:0] dxr;
		logic [MagW-1:0] dyt;
		logic [MagW-1:0] dyb;
		logic [R2W-1:0]  r2;
		logic            in_box;
		logic            vert_in;
		logic            horz_in;
	} item_t;

endpackage
`default_nettype wire

[rtl/cac_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cac_front
// accepts items, forms clamped distances and the region flags
// ----------------------------------------------------------------------------
module cac_front #(
	parameter int COORD_BITS = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  signed [COORD_BITS-1:0]     center_x,
	input  wire  signed [COORD_BITS-1:0]     center_y,
	input  wire         [31:0]               radius_squared,
	input  wire  signed [COORD_BITS-1:0]     rect_left,
	input  wire  signed [COORD_BITS-1:0]     rect_top,
	input  wire         [COORD_BITS-2:0]     rect_width,
	input  wire         [COORD_BITS-2:0]     rect_height,
	input  wire                              q_full,
	output logic                             push,
	output cac_pkg::item_t                   item
);
	localparam int DW = (COORD_BITS + 2 > cac_pkg::MagW + 1) ?
		COORD_BITS + 2 : cac_pkg::MagW + 1;

	function automatic logic [cac_pkg::MagW-1:0] mag(input logic signed [DW-1:0] d);
		logic [DW-1:0] a;
		a = d[DW-1] ? DW'(-d) : DW'(d);
		return (a > DW'(cac_pkg::Clamp)) ? cac_pkg::MagW'(cac_pkg::Clamp)
			: a[cac_pkg::MagW-1:0];
	endfunction

	logic signed [DW-1:0] cx, cy, lx, ty, rx, by, dl, dr, dt, db;
	logic                 valid_s1;
	cac_pkg::item_t       item_s1;
	cac_pkg::item_t       cls;
	logic                 en;

	always_comb begin
		cx = DW'(center_x);
		cy = DW'(center_y);
		lx = DW'(rect_left);
		ty = DW'(rect_top);
		rx = lx + DW'(signed'({1'b0, rect_width}));
		by = ty + DW'(signed'({1'b0, rect_height}));
		dl = lx - cx;
		dr = rx - cx;
		dt = ty - cy;
		db = by - cy;
		cls.dxl = mag(dl);
		cls.dxr = mag(dr);
		cls.dyt = mag(dt);
		cls.dyb = mag(db);
		cls.r2 = radius_squared;
		cls.in_box = (dl < 0) && (dr > 0) && (dt < 0) && (db > 0);
		cls.vert_in = (dt <= 0) && (db >= 0) && (rect_height != '0);
		cls.horz_in = (dl <= 0) && (dr >= 0) && (rect_width != '0);
	end

	assign en = !valid_s1 || !q_full;
	assign in_stall = !en;
	assign push = valid_s1 && !q_full;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			item_s1 <= cls;
		end
	end

endmodule
`default_nettype wire

[rtl/cac_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cac_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module cac_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  cac_pkg::item_t  wr_item,
	output logic            full,
	input  wire             pop,
	output logic            not_empty,
	output cac_pkg::item_t  rd_item
);
	cac_pkg::item_t mem_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     cnt_q;

	assign full = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule
`default_nettype wire

[rtl/cac_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cac_back
// squares the distances, compares against the radius, drives the result
// ----------------------------------------------------------------------------
module cac_back (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             q_valid,
	input  cac_pkg::item_t  q_item,
	output logic            pop,
	output logic            out_valid,
	input  wire             out_stall,
	output logic            hit
);
	logic [cac_pkg::SqW-1:0]  sxl_s2, sxr_s2, syt_s2, syb_s2;
	logic [cac_pkg::R2W-1:0]  r2_s2;
	logic                     in_box_s2, vert_s2, horz_s2, valid_s2;
	logic                     en, hit_c;
	logic [cac_pkg::SumW-1:0] r2e;

	assign en = !out_valid || !out_stall;
	assign pop = en && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s2 <= q_valid;
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sxl_s2 <= cac_pkg::SqW'(q_item.dxl) * cac_pkg::SqW'(q_item.dxl);
			sxr_s2 <= cac_pkg::SqW'(q_item.dxr) * cac_pkg::SqW'(q_item.dxr);
			syt_s2 <= cac_pkg::SqW'(q_item.dyt) * cac_pkg::SqW'(q_item.dyt);
			syb_s2 <= cac_pkg::SqW'(q_item.dyb) * cac_pkg::SqW'(q_item.dyb);
			r2_s2 <= q_item.r2;
			in_box_s2 <= q_item.in_box;
			vert_s2 <= q_item.vert_in;
			horz_s2 <= q_item.horz_in;
			hit <= hit_c;
		end
	end

	always_comb begin
		r2e = cac_pkg::SumW'(r2_s2);
		hit_c = in_box_s2
			|| ({1'b0, sxl_s2} + {1'b0, syt_s2} <= r2e)
			|| ({1'b0, sxl_s2} + {1'b0, syb_s2} <= r2e)
			|| ({1'b0, sxr_s2} + {1'b0, syt_s2} <= r2e)
			|| ({1'b0, sxr_s2} + {1'b0, syb_s2} <= r2e)
			|| (vert_s2 && ({1'b0, sxl_s2} <= r2e || {1'b0, sxr_s2} <= r2e))
			|| (horz_s2 && ({1'b0, syt_s2} <= r2e || {1'b0, syb_s2} <= r2e));
	end

endmodule
`default_nettype wire

[rtl/circle_aabb_collision.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// circle_aabb_collision
// circle versus axis-aligned box hit test, when not stalled one transfer per cycle
// ----------------------------------------------------------------------------
// One item per clock is taken when not stalled; one hit flag returns per item, in order.
// Input transfers pass the front classify register, the queue, the squaring
// register and the output register. The sustained rate is one item per cycle
// with out_stall low, set by the fully pipelined squaring stage; the two-entry
// queue lets the front accept while the output is stalled, until it fills.
// ----------------------------------------------------------------------------
module circle_aabb_collision #(
	parameter int COORD_BITS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  signed [COORD_BITS-1:0] center_x,
	input  wire  signed [COORD_BITS-1:0] center_y,
	input  wire         [31:0]           radius_squared,
	input  wire  signed [COORD_BITS-1:0] rect_left,
	input  wire  signed [COORD_BITS-1:0] rect_top,
	input  wire         [COORD_BITS-2:0] rect_width,
	input  wire         [COORD_BITS-2:0] rect_height,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         hit
);
	// front to queue
	logic           push, q_full;
	cac_pkg::item_t f_item;
	// queue to back
	logic           pop, q_valid;
	cac_pkg::item_t q_item;

	// classify: distances to the box lines, clamped, plus inside / span flags
	cac_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.center_x(center_x), .center_y(center_y),
		.radius_squared(radius_squared),
		.rect_left(rect_left), .rect_top(rect_top),
		.rect_width(rect_width), .rect_height(rect_height),
		.q_full(q_full), .push(push), .item(f_item)
	);

	// decouples the front from output stalls
	cac_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wr_item(f_item), .full(q_full),
		.pop(pop), .not_empty(q_valid), .rd_item(q_item)
	);

	// corner, edge-projection and inside decisions
	cac_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_item(q_item), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .hit(hit)
	);

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid) else $error("pop from empty queue");
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (push || q_full))
		else $error("accepted transfer not held in front stage");
`endif

endmodule
`default_nettype wire

[bench/circle_aabb_collision_checker.sv]
// ----------------------------------------------------------------------------
// circle_aabb_collision_checker
// watches both channels, predicts the hit flag of each input transfer and
// compares it with the result transfers in order
// ----------------------------------------------------------------------------
module circle_aabb_collision_checker #(
	parameter int COORD_BITS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire                          in_stall,
	input  wire  signed [COORD_BITS-1:0] center_x,
	input  wire  signed [COORD_BITS-1:0] center_y,
	input  wire         [31:0]           radius_squared,
	input  wire  signed [COORD_BITS-1:0] rect_left,
	input  wire  signed [COORD_BITS-1:0] rect_top,
	input  wire         [COORD_BITS-2:0] rect_width,
	input  wire         [COORD_BITS-2:0] rect_height,
	input  wire                          out_valid,
	input  wire                          out_stall,
	input  wire                          hit,
	output int                           fail_count,
	output int                           pending_hits
);

	bit expected_hits[$];
	int fails = 0;

	function automatic longint mag_clamped(longint d);
		if (d < 0) d = -d;
		return (d > cac_pkg::Clamp) ? longint'(cac_pkg::Clamp) : d;
	endfunction

	function automatic bit near_pt(longint px, longint py, longint cx, longint cy,
			longint r2);
		longint dx, dy;
		dx = mag_clamped(px - cx);
		dy = mag_clamped(py - cy);
		return (dx * dx + dy * dy) <= r2;
	endfunction

	function automatic int sign_of(longint v);
		return int'(v > 0) - int'(v < 0);
	endfunction

	function automatic bit edge_hit(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy, longint r2);
		if (near_pt(ax, ay, cx, cy, r2) || near_pt(bx, by, cx, cy, r2)) return 1;
		if (ax == bx && ay == by) return 0;
		if (ax == bx) begin
			if (sign_of(by - ay) * sign_of(cy - ay) < 0) return 0;
			if (sign_of(ay - by) * sign_of(cy - by) < 0) return 0;
			return near_pt(ax, cy, cx, cy, r2);
		end
		if (sign_of(bx - ax) * sign_of(cx - ax) < 0) return 0;
		if (sign_of(ax - bx) * sign_of(cx - bx) < 0) return 0;
		return near_pt(cx, ay, cx, cy, r2);
	endfunction

	function automatic bit collide(longint cx, longint cy, longint r2, longint l,
			longint t, longint w, longint h);
		longint r, b;
		r = l + w;
		b = t + h;
		if (cx > l && cx < r && cy > t && cy < b) return 1;
		return edge_hit(l, t, l, b, cx, cy, r2) || edge_hit(l, b, r, b, cx, cy, r2)
			|| edge_hit(r, b, r, t, cx, cy, r2) || edge_hit(r, t, l, t, cx, cy, r2);
	endfunction

	task automatic report(string what);
		$display("mismatch: %s at %0t", what, $realtime);
		fails++;
	endtask

	assign pending_hits = expected_hits.size();
	assign fail_count = fails;

	always @(posedge clk) begin
		bit want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_hits.push_back(collide(longint'(center_x),
					longint'(center_y), longint'(radius_squared),
					longint'(rect_left), longint'(rect_top),
					longint'(rect_width), longint'(rect_height)));
			if (out_valid && !out_stall) begin
				if (expected_hits.size() == 0) begin
					report("result transfer with nothing expected");
				end else begin
					want = expected_hits.pop_front();
					if (hit !== want)
						report($sformatf("hit got %b want %b", hit, want));
				end
			end
		end
	end

endmodule

[bench/circle_aabb_collision_tb.sv]
// ----------------------------------------------------------------------------
// circle_aabb_collision_tb
// stimulus and verdict for the circle / box collision block
// ----------------------------------------------------------------------------
// directed corner cases first, then random pairs biased toward boxes near the
// circle; both channels idle in random bursts, the receiver once holds off for
// a long stretch and the sender drains twice; the last part runs at full rate
// ----------------------------------------------------------------------------
module circle_aabb_collision_tb;

	localparam int CB = 16;
	localparam int RANDOM_ITEMS = 650;
	localparam int WATCHDOG = 2000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [CB-1:0] center_x = '0, center_y = '0, rect_left = '0, rect_top = '0;
	logic [31:0] radius_squared = '0;
	logic [CB-2:0] rect_width = '0, rect_height = '0;
	logic out_valid;
	logic out_stall = 0;
	logic hit;
	int fail_count, pending_hits;
	bit quiet = 0;      // no idling in the final stretch
	bit hold_off = 0;   // receiver long stall request
	int idle_cycles = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	circle_aabb_collision #(.COORD_BITS(CB)) dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.center_x(center_x), .center_y(center_y), .radius_squared(radius_squared),
		.rect_left(rect_left), .rect_top(rect_top), .rect_width(rect_width),
		.rect_height(rect_height), .out_valid(out_valid), .out_stall(out_stall),
		.hit(hit)
	);

	circle_aabb_collision_checker #(.COORD_BITS(CB)) checker_i (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.center_x(center_x), .center_y(center_y), .radius_squared(radius_squared),
		.rect_left(rect_left), .rect_top(rect_top), .rect_width(rect_width),
		.rect_height(rect_height), .out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .fail_count(fail_count), .pending_hits(pending_hits)
	);

	// one transfer on the input channel, then one optional idle burst
	task automatic send(int cx, int cy, longint r2, int l, int t, int w, int h);
		int gap;
		@(negedge clk);
		center_x = CB'(cx); center_y = CB'(cy); radius_squared = 32'(r2);
		rect_left = CB'(l); rect_top = CB'(t);
		rect_width = (CB-1)'(w); rect_height = (CB-1)'(h);
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			in_valid = 0;
			gap = $urandom_range(1, 5);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (pending_hits != 0) @(posedge clk);
	endtask

	// random pair: mostly a box near the circle with a radius of matching scale
	task automatic send_random();
		int cx, cy, l, t, w, h, sc;
		longint r2;
		cx = int'($signed(16'($urandom)));
		cy = int'($signed(16'($urandom)));
		case ($urandom_range(0, 9))
			0: begin
				l = int'($signed(16'($urandom))); t = int'($signed(16'($urandom)));
				w = $urandom_range(0, 32767); h = $urandom_range(0, 32767);
				r2 = longint'($urandom);
			end
			default: begin
				sc = 1 << $urandom_range(0, 14);
				l = cx + $signed($urandom_range(0, 4 * sc)) - 2 * sc;
				t = cy + $signed($urandom_range(0, 4 * sc)) - 2 * sc;
				if (l > 32767) l = 32767; if (l < -32768) l = -32768;
				if (t > 32767) t = 32767; if (t < -32768) t = -32768;
				w = $urandom_range(0, 2 * sc); h = $urandom_range(0, 2 * sc);
				if (w > 32767) w = 32767; if (h > 32767) h = 32767;
				if ($urandom_range(0, 7) == 0) w = 0;
				if ($urandom_range(0, 7) == 0) h = 0;
				r2 = longint'($urandom_range(0, sc)) * longint'($urandom_range(0, sc));
				if ($urandom_range(0, 9) == 0) r2 = longint'($urandom);
			end
		endcase
		send(cx, cy, r2, l, t, w, h);
	endtask

	// receiver: random stall bursts, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_off) begin
			out_stall <= 1;
		end else if (quiet) begin
			out_stall <= 0;
		end else if ($urandom_range(0, 7) == 0) begin
			out_stall <= 1;
			repeat ($urandom_range(1, 5) - 1) @(negedge clk);
		end else begin
			out_stall <= 0;
		end
	end

	// long hold-off counted here so the block backs up while the sender runs on
	initial begin
		wait (arst_n);
		repeat (150) @(posedge clk);
		hold_off = 1;
		repeat (40) @(posedge clk);
		hold_off = 0;
	end

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: extremes, inside, on edges, zero sides, far points
		send(0, 0, 0, -10, -10, 20, 20);                   // strictly inside
		send(-10, 0, 0, -10, -10, 20, 20);                 // on left edge
		send(-10, -10, 0, -10, -10, 20, 20);               // on corner
		send(0, 10, 0, -10, -10, 20, 20);                  // on bottom edge
		send(0, 0, 0, 0, 0, 0, 0);                         // point box on center
		send(0, 0, 0, 1, 0, 0, 0);                         // point box just off
		send(5, 0, 0, 0, -3, 0, 6);                        // zero width, projection
		send(0, 5, 0, -3, 0, 6, 0);                        // zero height, projection
		send(5, 0, 24, 0, -3, 0, 6);                       // projection just out
		send(5, 0, 25, 0, -3, 0, 6);                       // projection just in
		send(-32768, -32768, 32'hFFFF_FFFF, 32767, 32767, 32767, 32767); // far
		send(32767, 32767, 32'hFFFF_FFFF, -32768, -32768, 0, 0);
		send(32767, 32767, 0, -32768, -32768, 32767, 32767);
		send(-32768, 32767, 32'hFFFF_FFFF, 32767, -32768, 32767, 32767);
		send(0, 0, 32'hFFFF_FFFF, -32768, -32768, 32767, 32767);
		send(-32768, -32768, 0, -32768, -32768, 32767, 32767);
		send(100, 100, 2, 90, 90, 9, 9);                   // corner diagonal
		send(100, 100, 162, 90, 90, 9, 9);
		send(-5, 3, 100, 0, 0, 10, 10);                    // left side projection
		send(3, 20, 99, 0, 0, 10, 10);                     // bottom side projection
		drain();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2) drain();            // sender pauses
			if (i == RANDOM_ITEMS - 100) quiet = 1;
			send_random();
		end
		@(negedge clk);
		in_valid = 0;
		while (pending_hits != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[circle_aabb_collision.f]
rtl/cac_pkg.sv
rtl/cac_front.sv
rtl/cac_queue.sv
rtl/cac_back.sv
rtl/circle_aabb_collision.sv
bench/circle_aabb_collision_checker.sv
bench/circle_aabb_collision_tb.sv
